@@ design/ssh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types, codes and tables for the PDCCH search-space CCE hash block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // Default sizing of the block
  localparam int MAX_CANDIDATES_DEF  = 8;
  localparam int SLOTS_PER_FRAME_DEF = 320;

  // Hash arithmetic
  localparam int unsigned MAX_LEVEL_CODE = 4;
  localparam int          DIV_W          = 18;  // dividend width of the shared divider
  localparam int          DIV_STEPS      = 18;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  // Hash multipliers, picked by CORESET id modulo 3
  localparam logic [15:0] HASH_A0 = 16'd39827;
  localparam logic [15:0] HASH_A1 = 16'd39829;
  localparam logic [15:0] HASH_A2 = 16'd39839;

  typedef struct packed {
    logic        common_space;
    logic [15:0] rnti;
    logic [8:0]  slot_num;
    logic [3:0]  coreset_id;
    logic [2:0]  agg_level_code;
    logic [3:0]  candidate_count;
    logic [7:0]  coreset_cces;
  } ssh_in_t;

  typedef struct packed {
    logic [7:0] cce_index;
    logic [2:0] candidate_index;
    logic       last;
    logic [1:0] status;
  } ssh_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_OFF_GO,
    S_OFF_WAIT,
    S_MOD_GO,
    S_MOD_WAIT,
    S_EMIT,
    S_FLAG
  } ssh_state_t;

  // Pick the hash multiplier from the CORESET id (id modulo 3)
  function automatic logic [15:0] ssh_hash_mult(input logic [3:0] id);
    logic [15:0] a;
    case (id) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: a = HASH_A0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       a = HASH_A1;
      default:                              a = HASH_A2;
    endcase
    return a;
  endfunction

endpackage

@@ design/ssh_hash.sv @@
// ----------------------------------------------------------------------------
// ssh_hash
// Iterative hash unit: Y = rnti * A^(slot+1) mod 65537, one modular
// multiplication per cycle.
// ----------------------------------------------------------------------------
module ssh_hash
  import ssh_pkg::*;
#(
  parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] rnti,
  input  logic [8:0]  slot_num,
  input  logic [3:0]  coreset_id,
  output logic        done,
  output logic [16:0] y
);

  localparam int CntW = $clog2(SLOTS_PER_FRAME + 1);

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     prod_r, prod_nxt;
  logic [15:0]     a_r, a_nxt;
  logic [15:0]     lo, hi;
  logic [32:0]     prod;

  // Reduce the stored product modulo 2^16+1: lo - hi, folded once
  always_comb begin
    lo = prod_r[15:0];
    hi = prod_r[31:16];
    if (lo >= hi) begin
      y = {1'b0, lo} - {1'b0, hi};
    end else begin
      y = {1'b0, lo} + 17'h10001 - {1'b0, hi};
    end
  end

  assign prod = {16'b0, y} * {17'b0, a_r};
  assign done = busy_r && (cnt_r == '0);

  // Advance one multiplication per cycle until the count runs out
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    a_nxt    = a_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(slot_num) + CntW'(1);
      prod_nxt = {16'b0, rnti};
      a_nxt    = ssh_hash_mult(coreset_id);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r - CntW'(1);
        prod_nxt = prod[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
  end

endmodule

@@ design/ssh_div.sv @@
// ----------------------------------------------------------------------------
// ssh_div
// Shared restoring divider: 18-bit dividend by 8-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ssh_div
  import ssh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [7:0]       remainder
);

  localparam int CntW = $clog2(DIV_STEPS + 1);

  logic             busy_r, busy_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       dvs_r, dvs_nxt;
  logic [8:0]       trial;
  logic [8:0]       diff;
  logic             fits;

  assign done      = busy_r && (cnt_r == '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DIV_STEPS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CntW'(1);
        quo_nxt = {quo_r[DIV_W-2:0], fits};
        rem_nxt = fits ? diff[7:0] : trial[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

@@ design/pdcch_search_space_cce_hash.sv @@
// ----------------------------------------------------------------------------
// pdcch_search_space_cce_hash
// Lowest CCE index of every PDCCH candidate of one search-space request.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only while the block is
// idle. A UE-specific request first runs the hash loop, one modular
// multiplication per cycle; a common-space request skips it. Each
// candidate then makes two passes through the shared 18-step divider
// (offset, then modulo over the CCE blocks). An empty or invalid request
// gives its single status item. Results leave through an output register,
// so a pending item does not stall the work on the next candidate until
// the next item is ready.
// ----------------------------------------------------------------------------
module pdcch_search_space_cce_hash
  import ssh_pkg::*;
#(
  parameter int MAX_CANDIDATES  = MAX_CANDIDATES_DEF,
  parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssh_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ssh_out_t out_data
);

  ssh_state_t state_r, state_nxt;

  logic [2:0]  code_r, code_nxt;
  logic [3:0]  mcnt_r, mcnt_nxt;
  logic [7:0]  ncce_r, ncce_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [11:0] num_r, num_nxt;
  logic [16:0] y_r, y_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [1:0]  stat_r, stat_nxt;

  logic     out_valid_r, out_valid_nxt;
  ssh_out_t out_data_r, out_data_nxt;

  logic             in_fire;
  logic             out_free;
  logic             is_last;
  logic [1:0]       in_status;
  logic [8:0]       in_level;
  logic             bad_field;
  logic             hash_start;
  logic             hash_done;
  logic [16:0]      hash_y;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_dividend;
  logic [7:0]       div_divisor;
  logic [DIV_W-1:0] div_quo;
  logic [7:0]       div_rem;

  // Classify the incoming request
  always_comb begin
    in_level  = 9'd1 << in_data.agg_level_code;
    bad_field = (in_data.coreset_cces == 8'd0) ||
                (int'(in_data.agg_level_code) > int'(MAX_LEVEL_CODE)) ||
                (int'(in_data.candidate_count) > MAX_CANDIDATES) ||
                (int'(in_data.slot_num) >= SLOTS_PER_FRAME);
    if (bad_field) begin
      in_status = STATUS_BAD;
    end else if (in_data.candidate_count == 4'd0) begin
      in_status = STATUS_EMPTY;
    end else if (in_level > {1'b0, in_data.coreset_cces}) begin
      in_status = STATUS_BAD;
    end else begin
      in_status = STATUS_OK;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_last  = ((m_r + 4'd1) == mcnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_status != STATUS_OK) begin
            state_nxt = S_FLAG;
          end else if (in_data.common_space) begin
            state_nxt = S_OFF_GO;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_OFF_GO;
        end
      end
      S_OFF_GO:   state_nxt = S_OFF_WAIT;
      S_OFF_WAIT: begin
        if (div_done) begin
          state_nxt = S_MOD_GO;
        end
      end
      S_MOD_GO:   state_nxt = S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = is_last ? S_IDLE : S_OFF_GO;
        end
      end
      S_FLAG: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs: handshake and unit starts
  always_comb begin
    in_ready   = 1'b0;
    hash_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        hash_start = in_valid && (in_status == STATUS_OK) && !in_data.common_space;
      end
      S_OFF_GO, S_MOD_GO: div_start = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Feed the shared divider: offset pass, then modulo pass
  always_comb begin
    if (state_r == S_OFF_GO) begin
      div_dividend = {{(DIV_W-12){1'b0}}, num_r};
      div_divisor  = {4'b0, mcnt_r} << code_r;
    end else begin
      div_dividend = DIV_W'({1'b0, y_r} + {10'b0, off_r});
      div_divisor  = ncce_r >> code_r;
    end
  end

  // Datapath registers
  always_comb begin
    code_nxt = code_r;
    mcnt_nxt = mcnt_r;
    ncce_nxt = ncce_r;
    m_nxt    = m_r;
    num_nxt  = num_r;
    y_nxt    = y_r;
    off_nxt  = off_r;
    rem_nxt  = rem_r;
    stat_nxt = stat_r;
    if (in_fire) begin
      code_nxt = in_data.agg_level_code;
      mcnt_nxt = in_data.candidate_count;
      ncce_nxt = in_data.coreset_cces;
      m_nxt    = '0;
      num_nxt  = '0;
      y_nxt    = '0;
      stat_nxt = in_status;
    end
    if ((state_r == S_HASH) && hash_done) begin
      y_nxt = hash_y;
    end
    if ((state_r == S_OFF_WAIT) && div_done) begin
      off_nxt = div_quo[7:0];
    end
    if ((state_r == S_MOD_WAIT) && div_done) begin
      rem_nxt = div_rem;
    end
    // Advance to the next candidate
    if ((state_r == S_EMIT) && out_free) begin
      m_nxt   = m_r + 4'd1;
      num_nxt = num_r + {4'b0, ncce_r};
    end
  end

  // Output register: hold until taken, load a new item when free
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if ((state_r == S_EMIT) && out_free) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.cce_index       = rem_r << code_r;
      out_data_nxt.candidate_index = m_r[2:0];
      out_data_nxt.last            = is_last;
      out_data_nxt.status          = STATUS_OK;
    end else if ((state_r == S_FLAG) && out_free) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.cce_index       = '0;
      out_data_nxt.candidate_index = '0;
      out_data_nxt.last            = 1'b1;
      out_data_nxt.status          = stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      m_r         <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    mcnt_r     <= mcnt_nxt;
    ncce_r     <= ncce_nxt;
    num_r      <= num_nxt;
    y_r        <= y_nxt;
    off_r      <= off_nxt;
    rem_r      <= rem_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  ssh_hash #(
    .SLOTS_PER_FRAME(SLOTS_PER_FRAME)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (hash_start),
    .rnti      (in_data.rnti),
    .slot_num  (in_data.slot_num),
    .coreset_id(in_data.coreset_id),
    .done      (hash_done),
    .y         (hash_y)
  );

  ssh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

endmodule
